### src/tpg_pkg.sv
package tpg_pkg;

  // number format
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DT_BITS   = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned DT_W      = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1 << FRAC_BITS);

  // multiplier operands are one bit wider than the data so unsigned values fit as positives
  localparam int unsigned MUL_OP_W  = DATA_W + 1;
  localparam int unsigned PROD_W    = 64;

  // vmax^2 / (2 amax): the quotient has 31 bits and is only right while it stays below 2^31
  localparam int unsigned DIVIDEND_W = 2 * LIMIT_W;
  localparam int unsigned DIVISOR_W  = LIMIT_W + 1;
  localparam int unsigned QUOT_W     = LIMIT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W);

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/trapezoidal_profile_generator_unit.sv
// trapezoidal motion profile generator
//
// input channel (in_valid_i / in_ready_o): func_i selects a start transfer,
// which loads start_position_i and target_position_i, or a tick transfer,
// which advances the profile by elapsed_time_i (Q0.16 seconds). positions,
// velocities and limits are Q15.16.
// output channel (out_valid_o / out_ready_i): exactly one result transfer per
// input transfer, in order: position, velocity, acceleration, at_setpoint.
// config port: cfg_we_i writes max_velocity (index 0) or max_acceleration
// (index 1); a write of zero is dropped. write only while idle.
// sequencing: one item at a time through a shared 33x33 multiplier and a
// radix-2 divider. a tick steps through ST_DV, ST_DP and ST_UPD; a start
// through ST_VSQ, ST_CMP and ST_TRI, where a triangle move ends, else on
// through ST_DIV, where the divider forms vmax^2 / (2 amax) one quotient bit
// at a time, and ST_UPD. in_ready_o rises with the edge that loads the output
// register, so the next item can be taken while the result waits.
// stall: if the receiver holds out_ready_i low, a finished item waits in its
// last step until the output register frees up; nothing is dropped.
// reset: both limits go to 1.0, the profile state clears to zero and no
// profile counts as started, so at_setpoint_o stays low until a start.
module trapezoidal_profile_generator_unit import tpg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [LIMIT_W-1:0]       cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] start_position_i,
  input  logic signed [DATA_W-1:0] target_position_i,
  input  logic [DT_W-1:0]          elapsed_time_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] position_o,
  output logic signed [DATA_W-1:0] velocity_o,
  output logic signed [DATA_W-1:0] acceleration_o,
  output logic                     at_setpoint_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_VSQ  = 8'b0000_0010,  // vmax * vmax
    ST_CMP  = 8'b0000_0100,  // distance * amax
    ST_TRI  = 8'b0000_1000,  // triangle or trapezoid decision
    ST_DIV  = 8'b0001_0000,  // wait for the divider
    ST_DV   = 8'b0010_0000,  // amax * dt
    ST_DP   = 8'b0100_0000,  // velocity * dt
    ST_UPD  = 8'b1000_0000   // integrate a tick and load the output register
  } state_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic {
    REG_MAX_VELOCITY     = 1'b0,
    REG_MAX_ACCELERATION = 1'b1
  } reg_idx_e;

  state_e state_q, state_d;

  // limits
  logic [LIMIT_W-1:0] vmax_q, amax_q;

  // profile state
  logic signed [DATA_W-1:0] goal_q, pos_q, vel_q, acc_q, decel_q;
  logic                     started_q;

  // working registers
  logic [DATA_W-1:0]  dist_q;
  logic [DT_W-1:0]    dt_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  vsq_q;
  logic [LIMIT_W-1:0] dv_q;
  logic               out_slot_free;

  // output register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] position_q, velocity_q, acceleration_q;
  logic                     at_setpoint_q;

  logic in_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // output register is free when empty or being drained this cycle
  assign out_slot_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------
  // shared multiplier, operands picked by the sequencer state
  // ---------------------------------------------------------------------
  logic signed [MUL_OP_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_OP_W-1:0] mul_p;

  always_comb begin
    case (state_q)
      ST_VSQ: begin
        mul_a = signed'(MUL_OP_W'(vmax_q));
        mul_b = signed'(MUL_OP_W'(vmax_q));
      end
      ST_CMP: begin
        mul_a = signed'(MUL_OP_W'(dist_q));
        mul_b = signed'(MUL_OP_W'(amax_q));
      end
      ST_DV: begin
        mul_a = signed'(MUL_OP_W'(amax_q));
        mul_b = signed'(MUL_OP_W'(dt_q));
      end
      ST_DP: begin
        mul_a = MUL_OP_W'(vel_q);
        mul_b = signed'(MUL_OP_W'(dt_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------
  // divider for the deceleration distance vmax^2 / (2 amax)
  // ---------------------------------------------------------------------
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [QUOT_W-1:0]  div_quot;
  logic               is_triangle;

  // triangle when the distance is too short to reach full speed
  assign is_triangle    = prod_q < vsq_q;
  assign div_ctrl.start = (state_q == ST_TRI) && !is_triangle;

  tpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (vsq_q[DIVIDEND_W-1:0]),
    .divisor_i  ({amax_q, 1'b0}),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  // ---------------------------------------------------------------------
  // start item arithmetic
  // ---------------------------------------------------------------------
  logic signed [DATA_W:0] span;
  logic signed [DATA_W:0] span_abs;
  logic signed [DATA_W:0] mid_sum;
  logic signed [DATA_W:0] decel_trap;
  logic signed [DATA_W:0] quot_ext;
  logic signed [DATA_W-1:0] amax_pos, amax_neg;

  assign span     = signed'({target_position_i[DATA_W-1], target_position_i}) -
                    signed'({start_position_i[DATA_W-1], start_position_i});
  assign span_abs = span[DATA_W] ? -span : span;

  assign amax_pos = signed'(DATA_W'(amax_q));
  assign amax_neg = -amax_pos;

  assign mid_sum    = signed'({goal_q[DATA_W-1], goal_q}) +
                      signed'({pos_q[DATA_W-1], pos_q});
  assign quot_ext   = signed'((DATA_W + 1)'(div_quot));
  // goal and start still sit in goal_q and pos_q during the divide
  assign decel_trap = (goal_q > pos_q) ?
                      signed'({goal_q[DATA_W-1], goal_q}) - quot_ext :
                      signed'({goal_q[DATA_W-1], goal_q}) + quot_ext;

  // ---------------------------------------------------------------------
  // tick arithmetic
  // ---------------------------------------------------------------------
  localparam int unsigned VW = DATA_W + 2;

  logic signed [DATA_W-1:0] dp;
  logic signed [DATA_W:0]   pos_sum;
  logic signed [DATA_W-1:0] new_pos;
  logic signed [VW-1:0]     vel_ext, dv_ext, vmax_ext, vel_dn, vel_up, new_vel_ext;
  logic signed [DATA_W-1:0] new_vel;
  logic signed [DATA_W-1:0] new_acc;

  // floor(v * dt / 2^16): arithmetic shift of the signed product
  assign dp      = signed'(prod_q[DT_BITS+DATA_W-1:DT_BITS]);
  assign pos_sum = signed'({pos_q[DATA_W-1], pos_q}) + signed'({dp[DATA_W-1], dp});

  always_comb begin
    if (pos_sum > signed'((DATA_W + 1)'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      new_pos = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (pos_sum < signed'({2'b11, {(DATA_W-1){1'b0}}})) begin
      new_pos = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      new_pos = pos_sum[DATA_W-1:0];
    end
  end

  assign vel_ext  = VW'(vel_q);
  assign dv_ext   = signed'(VW'(dv_q));
  assign vmax_ext = signed'(VW'(vmax_q));
  assign vel_dn   = vel_ext - dv_ext;
  assign vel_up   = vel_ext + dv_ext;

  // ramp direction follows which side of the turn point we were on
  always_comb begin
    if (decel_q < goal_q) begin
      if (pos_q > decel_q) begin
        new_vel_ext = (vel_dn < 0) ? '0 : vel_dn;
      end else begin
        new_vel_ext = (vel_up > vmax_ext) ? vmax_ext : vel_up;
      end
    end else begin
      if (pos_q > decel_q) begin
        new_vel_ext = (vel_dn < -vmax_ext) ? -vmax_ext : vel_dn;
      end else begin
        new_vel_ext = (vel_up > 0) ? '0 : vel_up;
      end
    end
  end

  assign new_vel = new_vel_ext[DATA_W-1:0];

  always_comb begin
    if (new_vel == vel_q) begin
      new_acc = '0;
    end else if (new_vel > vel_q) begin
      new_acc = amax_pos;
    end else begin
      new_acc = amax_neg;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (func_i == FUNC_TICK) ? ST_DV : ST_VSQ;
        end
      end
      ST_VSQ: state_d = ST_CMP;
      ST_CMP: state_d = ST_TRI;
      ST_TRI: begin
        if (is_triangle) begin
          if (out_slot_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_UPD;
        end
      end
      ST_DV: state_d = ST_DP;
      ST_DP: state_d = ST_UPD;
      ST_UPD: begin
        if (out_slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result load: triangle starts finish in ST_TRI, the rest in ST_UPD
  logic load_out;
  logic upd_tick;
  assign load_out = out_slot_free &&
                    (((state_q == ST_TRI) && is_triangle) || (state_q == ST_UPD));
  // ST_UPD after a divide carries a start result, after ST_DP a tick result
  logic from_div_q;
  assign upd_tick = (state_q == ST_UPD) && !from_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vmax_q      <= LIMIT_RESET;
      amax_q      <= LIMIT_RESET;
      goal_q      <= '0;
      pos_q       <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      decel_q     <= '0;
      started_q   <= 1'b0;
      from_div_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i && (cfg_data_i != '0)) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MAX_VELOCITY:     vmax_q <= cfg_data_i;
          REG_MAX_ACCELERATION: amax_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_fire && (func_i == FUNC_START)) begin
        goal_q     <= target_position_i;
        pos_q      <= start_position_i;
        vel_q      <= '0;
        acc_q      <= (target_position_i < start_position_i) ? amax_neg : amax_pos;
        started_q  <= 1'b1;
      end

      if ((state_q == ST_TRI) && is_triangle) begin
        decel_q <= mid_sum[DATA_W:1];
      end

      if ((state_q == ST_DIV) && div_stat.done) begin
        decel_q    <= decel_trap[DATA_W-1:0];
        from_div_q <= 1'b1;
      end

      if (upd_tick && out_slot_free) begin
        pos_q <= new_pos;
        vel_q <= new_vel;
        acc_q <= new_acc;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == ST_IDLE) begin
        from_div_q <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dist_q <= span_abs[DATA_W-1:0];
      dt_q   <= elapsed_time_i;
    end
    if ((state_q == ST_VSQ) || (state_q == ST_CMP) ||
        (state_q == ST_DV) || (state_q == ST_DP)) begin
      prod_q <= mul_p[PROD_W-1:0];
    end
    if (state_q == ST_CMP) begin
      vsq_q <= prod_q;
    end
    if (state_q == ST_DP) begin
      dv_q <= prod_q[DT_BITS+LIMIT_W-1:DT_BITS];
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (upd_tick) begin
        position_q     <= new_pos;
        velocity_q     <= new_vel;
        acceleration_q <= new_acc;
        at_setpoint_q  <= (new_vel == '0) && started_q;
      end else begin
        position_q     <= pos_q;
        velocity_q     <= vel_q;
        acceleration_q <= acc_q;
        at_setpoint_q  <= (vel_q == '0) && started_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = position_q;
  assign velocity_o     = velocity_q;
  assign acceleration_o = acceleration_q;
  assign at_setpoint_o  = at_setpoint_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_setpoint_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && at_setpoint_o) |-> (velocity_o == '0))
    else $error("at_setpoint with nonzero velocity");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("result load lost");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("input ready while divider runs");

endmodule

### src/tpg_div.sv
module tpg_div import tpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [QUOT_W-1:0]     quotient_o,
  output div_stat_t             stat_o
);

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [QUOT_W-1:0]    low_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_diff;
  logic                 fits;

  // one restoring step per cycle
  assign trial      = {rem_q, low_q[QUOT_W-1]};
  assign fits       = trial >= {1'b0, divisor_q};
  assign trial_diff = trial - {1'b0, divisor_q};
  assign rem_d      = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q     <= DIVISOR_W'(dividend_i[DIVIDEND_W-1:QUOT_W]);
      low_q     <= dividend_i[QUOT_W-1:0];
      divisor_q <= divisor_i;
      quot_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign quotient_o  = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### verif/tpg_tb_pkg.sv
package tpg_tb_pkg;

  import tpg_pkg::*;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic {
    REG_MAX_VELOCITY     = 1'b0,
    REG_MAX_ACCELERATION = 1'b1
  } limit_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] acceleration;
    logic                     at_setpoint;
  } profile_sample_t;

endpackage

### verif/tpg_profile_checker.sv
module tpg_profile_checker
  import tpg_pkg::*;
  import tpg_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [LIMIT_W-1:0]       cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] start_position_i,
  input  logic signed [DATA_W-1:0] target_position_i,
  input  logic [DT_W-1:0]          elapsed_time_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] position_i,
  input  logic signed [DATA_W-1:0] velocity_i,
  input  logic signed [DATA_W-1:0] acceleration_i,
  input  logic                     at_setpoint_i,
  output int                       mismatch_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored limits and profile state
  logic [LIMIT_W-1:0] vmax_q;
  logic [LIMIT_W-1:0] amax_q;
  longint             goal_q;
  longint             pos_q;
  longint             vel_q;
  longint             acc_q;
  longint             decel_q;
  bit                 started_q;

  profile_sample_t expected_samples[$];
  int              failures;

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic profile_sample_t advance_profile(
    input logic                     fn,
    input logic signed [DATA_W-1:0] sp,
    input logic signed [DATA_W-1:0] tp,
    input logic [DT_W-1:0]          dt
  );
    longint          s, t, q, dt_l, dv, newp, newv, vmax_l, amax_l;
    logic [63:0]     move_len, vsq, amax_u;
    profile_sample_t r;
    vmax_l = longint'({33'd0, vmax_q});
    amax_l = longint'({33'd0, amax_q});
    amax_u = {33'd0, amax_q};
    if (fn == FUNC_START) begin
      s = longint'(sp);
      t = longint'(tp);
      move_len = (t >= s) ? $unsigned(t - s) : $unsigned(s - t);
      vsq = {33'd0, vmax_q} * {33'd0, vmax_q};
      goal_q = t;
      pos_q = s;
      vel_q = 0;
      acc_q = (t < s) ? -amax_l : amax_l;
      started_q = 1'b1;
      // short move never reaches vmax: turn around at the midpoint
      if (move_len * amax_u < vsq) begin
        decel_q = (t + s) >>> 1;
      end else begin
        q = longint'(vsq / (amax_u << 1));
        decel_q = (t > s) ? t - q : t + q;
      end
    end else begin
      dt_l = longint'({48'd0, dt});
      dv = (amax_l * dt_l) >>> DT_BITS;
      newp = clip32(pos_q + ((vel_q * dt_l) >>> DT_BITS));
      // turn test looks at the position before this update
      if (decel_q < goal_q) begin
        if (pos_q > decel_q) begin
          newv = vel_q - dv;
          if (newv < 0) newv = 0;
        end else begin
          newv = vel_q + dv;
          if (newv > vmax_l) newv = vmax_l;
        end
      end else begin
        if (pos_q > decel_q) begin
          newv = vel_q - dv;
          if (newv < -vmax_l) newv = -vmax_l;
        end else begin
          newv = vel_q + dv;
          if (newv > 0) newv = 0;
        end
      end
      if (newv == vel_q) acc_q = 0;
      else if (newv > vel_q) acc_q = amax_l;
      else acc_q = -amax_l;
      pos_q = newp;
      vel_q = newv;
    end
    r.position     = pos_q[DATA_W-1:0];
    r.velocity     = vel_q[DATA_W-1:0];
    r.acceleration = acc_q[DATA_W-1:0];
    r.at_setpoint  = (vel_q == 0) && started_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    profile_sample_t seen, want;
    if (!rst_ni) begin
      vmax_q    <= LIMIT_RESET;
      amax_q    <= LIMIT_RESET;
      goal_q    = 0;
      pos_q     = 0;
      vel_q     = 0;
      acc_q     = 0;
      decel_q   = 0;
      started_q = 1'b0;
      failures  = 0;
      expected_samples.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      // results first, so a transfer in the same cycle cannot match itself
      if (out_valid_i && out_ready_i) begin
        seen = '{position_i, velocity_i, acceleration_i, at_setpoint_i};
        if (expected_samples.size() == 0) begin
          if (failures < 10)
            $display("%t: result with nothing expected: pos %0d vel %0d acc %0d set %0b",
                     $time, seen.position, seen.velocity, seen.acceleration,
                     seen.at_setpoint);
          failures++;
        end else begin
          want = expected_samples.pop_front();
          if (seen !== want) begin
            if (failures < 10)
              $display("%t: mismatch exp pos %0d vel %0d acc %0d set %0b / got pos %0d vel %0d acc %0d set %0b",
                       $time, want.position, want.velocity, want.acceleration,
                       want.at_setpoint, seen.position, seen.velocity,
                       seen.acceleration, seen.at_setpoint);
            failures++;
          end
        end
      end
      // zero writes are dropped by the block
      if (cfg_we_i && cfg_data_i != '0) begin
        if (cfg_index_i == REG_MAX_VELOCITY) vmax_q <= cfg_data_i;
        else amax_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        expected_samples.push_back(advance_profile(func_i, start_position_i,
                                                   target_position_i, elapsed_time_i));
      mismatch_count_o <= failures;
      pending_o        <= expected_samples.size();
    end
  end

endmodule

### verif/trapezoidal_profile_generator_unit_tb.sv
module trapezoidal_profile_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpg_pkg::*;
  import tpg_tb_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 4000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = REG_MAX_VELOCITY;
  logic [LIMIT_W-1:0]       cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     func = FUNC_START;
  logic signed [DATA_W-1:0] start_position = '0;
  logic signed [DATA_W-1:0] target_position = '0;
  logic [DT_W-1:0]          elapsed_time = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] velocity;
  logic signed [DATA_W-1:0] acceleration;
  logic                     at_setpoint;

  int mismatches;
  int pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  int calm[2] = '{0, 0};

  // limits as the block holds them, used to scale the moves
  logic [LIMIT_W-1:0] vmax_set = LIMIT_RESET;
  logic [LIMIT_W-1:0] amax_set = LIMIT_RESET;

  trapezoidal_profile_generator_unit uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func),
    .start_position_i  (start_position),
    .target_position_i (target_position),
    .elapsed_time_i    (elapsed_time),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .position_o        (position),
    .velocity_o        (velocity),
    .acceleration_o    (acceleration),
    .at_setpoint_o     (at_setpoint)
  );

  tpg_profile_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .func_i            (func),
    .start_position_i  (start_position),
    .target_position_i (target_position),
    .elapsed_time_i    (elapsed_time),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .position_i        (position),
    .velocity_i        (velocity),
    .acceleration_i    (acceleration),
    .at_setpoint_i     (at_setpoint),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // wait before the next transfer: mostly a random gap, with bursts of back-to-back
  // traffic; side 0 is the input channel, side 1 the result channel
  function automatic int pick_wait(input int side);
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // tick lengths: mostly a few ms to a quarter second, sometimes the extremes
  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return DT_W'($urandom);
      default: return DT_W'($urandom_range(500, 16000));
    endcase
  endfunction

  // one input transfer; valid stays up after acceptance unless a gap follows
  task automatic send_item(input func_e fn, input logic [DATA_W-1:0] sp,
                           input logic [DATA_W-1:0] tp, input logic [DT_W-1:0] dt);
    int gap;
    gap = pick_wait(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    func            <= fn;
    start_position  <= sp;
    target_position <= tp;
    elapsed_time    <= dt;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // unused fields carry random values, the block must ignore them
  task automatic start_move(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] tp);
    send_item(FUNC_START, sp, tp, DT_W'($urandom));
  endtask

  task automatic tick(input logic [DT_W-1:0] dt);
    send_item(FUNC_TICK, $urandom, $urandom, dt);
  endtask

  // stop sending and wait until every result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input limit_reg_e idx, input logic [LIMIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (value != '0) begin
      if (idx == REG_MAX_VELOCITY) vmax_set = value;
      else amax_set = value;
    end
  endtask

  // new limits for a phase; the profile state carries over, so the first
  // ticks of a phase may run an old move under new limits
  task automatic pick_limits();
    logic [LIMIT_W-1:0] v, a;
    case ($urandom_range(0, 7))
      0:       begin v = LIMIT_W'(1); a = LIMIT_W'(1); end
      1:       begin v = '1;          a = '1;          end
      2:       begin v = '1;          a = LIMIT_W'(1); end
      3:       begin v = LIMIT_W'(1); a = '1;          end
      default: begin
        v = LIMIT_W'($urandom_range(1 << 14, 1 << 21));
        a = LIMIT_W'($urandom_range(1 << 14, 1 << 22));
      end
    endcase
    if ($urandom_range(0, 3) == 0) write_limit(REG_MAX_VELOCITY, '0);
    if ($urandom_range(0, 4) != 0) write_limit(REG_MAX_VELOCITY, v);
    if ($urandom_range(0, 3) == 0) write_limit(REG_MAX_ACCELERATION, '0);
    if ($urandom_range(0, 4) != 0) write_limit(REG_MAX_ACCELERATION, a);
  endtask

  // a start sized to the speed limit followed by a run of ticks, so the
  // profile passes through ramp up, cruise, ramp down and stop
  task automatic run_move(input int ticks);
    longint span, s, t;
    span = longint'({33'd0, vmax_set}) * $urandom_range(0, 600) / 100;
    s = longint'($signed($urandom)) >>> 1;
    t = $urandom_range(0, 1) ? s + span : s - span;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    start_move(s[DATA_W-1:0], t[DATA_W-1:0]);
    repeat (ticks) tick(pick_dt());
  endtask

  // result side: random stalls between transfers
  initial begin
    int w;
    forever begin
      w = pick_wait(1);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("trapezoidal_profile_generator_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int phase_end;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero writes must leave the reset limits in place
    write_limit(REG_MAX_VELOCITY, '0);
    write_limit(REG_MAX_ACCELERATION, '0);

    // ticks before any start run on the cleared state
    tick('1);
    tick('0);
    // full-range move, far enough to reach cruise speed
    start_move(32'h8000_0000, 32'h7fff_ffff);
    tick('1);
    tick(16'h8000);
    // zero-length move settles at once
    start_move(32'h1234_5678, 32'h1234_5678);
    tick(16'd100);
    tick('1);
    // downward move, negative acceleration
    start_move(32'h7fff_ffff, 32'h8000_0000);
    tick('1);
    tick(16'h4000);
    drain();

    // largest limits: velocity jumps to its clamp and position saturates
    write_limit(REG_MAX_VELOCITY, '1);
    write_limit(REG_MAX_ACCELERATION, '1);
    start_move(32'h7fff_0000, 32'h7fff_ffff);
    tick('1);
    tick('1);
    tick('1);
    start_move(32'h8001_0000, 32'h8000_0000);
    tick('1);
    tick('1);
    tick('1);
    drain();

    // smallest limits: one lsb per second
    write_limit(REG_MAX_VELOCITY, LIMIT_W'(1));
    write_limit(REG_MAX_ACCELERATION, LIMIT_W'(1));
    start_move(32'd0, 32'd1000);
    tick('1);
    tick('1);
    tick('1);

    // random phases, each under its own limits
    while (items_sent < 720) begin
      drain();
      pick_limits();
      phase_end = items_sent + 55;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0:       tick(DT_W'($urandom));
          1:       start_move($urandom, $urandom);
          2:       run_move($urandom_range(1, 3));   // cut short by the next start
          default: run_move($urandom_range(5, 45));
        endcase
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("trapezoidal_profile_generator_unit test passed");
    end else begin
      $display("trapezoidal_profile_generator_unit test failed");
    end
    $finish;
  end

endmodule
